// File: hw/rtl/csdm_pkg.sv
`timescale 1ns / 1ps
package csdm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_COUNT = 30;
  localparam int SAMPLE_W = 16;
  localparam int COORD_W = 18;
  localparam int OUT_W = 18;
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam int OUT_MAX = 65536;

  typedef enum logic [1:0] {
    WEDGE_EAST  = 2'd0,
    WEDGE_NORTH = 2'd1,
    WEDGE_WEST  = 2'd2,
    WEDGE_SOUTH = 2'd3
  } wedge_t;

  typedef struct packed {
    logic   valid;
    logic   origin;
    logic   neg;
    wedge_t wedge;
    logic [16:0] radius;
  } side_t;

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] t;
    begin
      case (idx)
        0: t = 30'd843314856;
        1: t = 30'd497837829;
        2: t = 30'd263043836;
        3: t = 30'd133525158;
        4: t = 30'd67021686;
        5: t = 30'd33543515;
        6: t = 30'd16775850;
        7: t = 30'd8388437;
        8: t = 30'd4194282;
        9: t = 30'd2097149;
        10: t = 30'd1048575;
        11: t = 30'd524287;
        12: t = 30'd262143;
        13: t = 30'd131071;
        14: t = 30'd65535;
        15: t = 30'd32767;
        16: t = 30'd16383;
        17: t = 30'd8191;
        18: t = 30'd4095;
        19: t = 30'd2047;
        20: t = 30'd1023;
        21: t = 30'd511;
        22: t = 30'd255;
        23: t = 30'd127;
        24: t = 30'd63;
        25: t = 30'd31;
        26: t = 30'd15;
        27: t = 30'd7;
        28: t = 30'd3;
        29: t = 30'd1;
        default: t = 30'd0;
      endcase
      return t;
    end
  endfunction

endpackage

// File: hw/rtl/csdm_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, carrying side data.
module csdm_divider
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [16:0]          num,
  input  logic [16:0]          den,
  input  side_t                side_in,
  output logic [FRAC_BITS:0]   quo,
  output side_t                side_out
);

  localparam int QW = FRAC_BITS + 1;
  localparam int RW = 18;

  logic [RW-1:0]   rem [1:QW];
  logic [16:0]     dv  [1:QW];
  logic [QW-1:0]   qa  [1:QW];
  side_t           sd  [1:QW];

  // The dividend is num*2^F; num <= den, so the top quotient bit position
  // is F. Rounding to nearest is applied after the last stage from the
  // final remainder.
  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [RW-1:0] rin;
    logic [16:0]   din;
    logic [QW-1:0] qin;
    side_t         sd_in;
    logic [RW:0]   trial;
    logic [RW-1:0] rbase;
    logic          bitq;
    if (s == 0) begin : g_head
      assign rin   = {1'b0, num};
      assign din   = den;
      assign qin   = '0;
      assign sd_in = side_in;
    end else begin : g_body
      assign rin   = rem[s];
      assign din   = dv[s];
      assign qin   = qa[s];
      assign sd_in = sd[s];
    end
    always_comb begin
      // Stage 0 tests num itself (quotient bit F), later stages shift in 0.
      if (s == 0) rbase = rin;
      else rbase = {rin[RW-2:0], 1'b0};
      trial = {1'b0, rbase} - {2'b00, din};
      bitq  = !trial[RW];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[s+1].valid <= 1'b0;
      end else begin
        sd[s+1].valid <= sd_in.valid;
      end
      sd[s+1].origin <= sd_in.origin;
      sd[s+1].neg    <= sd_in.neg;
      sd[s+1].wedge  <= sd_in.wedge;
      sd[s+1].radius <= sd_in.radius;
      rem[s+1] <= bitq ? trial[RW-1:0] : rbase;
      dv[s+1]  <= din;
      qa[s+1]  <= {qin[QW-2:0], bitq};
    end
  end

  // Round to nearest, ties up: add one when 2*rem >= den + (den odd ? 1:0),
  // i.e. rem + floor(den/2) >= den.
  logic [RW:0] rsum;
  always_comb begin
    rsum = {1'b0, rem[QW]} + {2'b00, 1'b0, dv[QW][16:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= sd[QW].valid;
    end
    side_out.origin <= sd[QW].origin;
    side_out.neg    <= sd[QW].neg;
    side_out.wedge  <= sd[QW].wedge;
    side_out.radius <= sd[QW].radius;
    quo <= qa[QW] + ((rsum >= {2'b00, dv[QW]}) ? QW'(1) : QW'(0));
  end

endmodule

// File: hw/rtl/csdm_cordic.sv
`timescale 1ns / 1ps
// Rotation CORDIC, one micro-rotation per register stage.
module csdm_cordic
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [FRAC_BITS+2:0] theta,
  input  side_t                       side_in,
  output logic signed [FRAC_BITS+2:0] cos_out,
  output logic signed [FRAC_BITS+2:0] sin_out,
  output side_t                       side_out
);

  localparam int NS = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
  localparam int W = FRAC_BITS + 3;
  localparam int TSH = 30 - FRAC_BITS;

  logic signed [W-1:0] xs [1:NS];
  logic signed [W-1:0] ys [1:NS];
  logic signed [W-1:0] zs [1:NS];
  side_t               sd [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic [29:0] STEP_FULL = atan_q30(i) >> TSH;
    localparam logic signed [W-1:0] STEP = W'(STEP_FULL);
    logic signed [W-1:0] xi;
    logic signed [W-1:0] yi;
    logic signed [W-1:0] zi;
    side_t               sd_in;
    logic signed [W-1:0] xsh;
    logic signed [W-1:0] ysh;
    if (i == 0) begin : g_head
      assign xi    = W'(GAIN_Q30 >> TSH);
      assign yi    = '0;
      assign zi    = theta;
      assign sd_in = side_in;
    end else begin : g_body
      assign xi    = xs[i];
      assign yi    = ys[i];
      assign zi    = zs[i];
      assign sd_in = sd[i];
    end
    always_comb begin
      xsh = xi >>> i;
      ysh = yi >>> i;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else begin
        sd[i+1].valid <= sd_in.valid;
      end
      sd[i+1].origin <= sd_in.origin;
      sd[i+1].neg    <= sd_in.neg;
      sd[i+1].wedge  <= sd_in.wedge;
      sd[i+1].radius <= sd_in.radius;
      if (!zi[W-1]) begin
        xs[i+1] <= xi - ysh;
        ys[i+1] <= yi + xsh;
        zs[i+1] <= zi - STEP;
      end else begin
        xs[i+1] <= xi + ysh;
        ys[i+1] <= yi - xsh;
        zs[i+1] <= zi + STEP;
      end
    end
  end

  assign cos_out  = xs[NS];
  assign sin_out  = ys[NS];
  assign side_out = sd[NS];

endmodule

// File: hw/rtl/concentric_square_to_disk_map_unit.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; busy is held low, so start may be high every cycle.
// The divider gives one quotient bit per stage and the CORDIC one rotation per stage.
// Reset (rst, synchronous, active high) clears all valid bits; no word is in flight after it.
// The receiver cannot stall: each result shows for exactly one cycle with strobe high.
module concentric_square_to_disk_map_unit
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [SAMPLE_W-1:0]      sample_x,
  input  logic [SAMPLE_W-1:0]      sample_y,
  output logic                     strobe,
  output logic signed [OUT_W-1:0]  disk_x,
  output logic signed [OUT_W-1:0]  disk_y
);

  localparam int F = FRAC_BITS;
  localparam int TW = F + 3;
  localparam int PW = F + 1 + 30;

  assign busy = 1'b0;

  // Stage A: wedge selection.
  logic signed [COORD_W-1:0] a_c, b_c;
  logic [16:0] mag_a, mag_b;
  side_t       sa_next, sa;
  logic [16:0] num_next, den_next, num_r, den_r;

  always_comb begin
    a_c = $signed({1'b0, sample_x, 1'b0}) - COORD_W'(65536);
    b_c = $signed({1'b0, sample_y, 1'b0}) - COORD_W'(65536);
    mag_a = a_c[COORD_W-1] ? 17'(-a_c) : a_c[16:0];
    mag_b = b_c[COORD_W-1] ? 17'(-b_c) : b_c[16:0];
    sa_next.valid = start;
    if (a_c > -b_c) begin
      if (a_c > b_c) begin
        sa_next.wedge = WEDGE_EAST;  sa_next.radius = mag_a; num_next = mag_b; den_next = mag_a;
      end else begin
        sa_next.wedge = WEDGE_NORTH; sa_next.radius = mag_b; num_next = mag_a; den_next = mag_b;
      end
    end else begin
      if (a_c < b_c) begin
        sa_next.wedge = WEDGE_WEST;  sa_next.radius = mag_a; num_next = mag_b; den_next = mag_a;
      end else begin
        sa_next.wedge = WEDGE_SOUTH; sa_next.radius = mag_b; num_next = mag_a; den_next = mag_b;
      end
    end
    sa_next.origin = (den_next == 17'd0);
    sa_next.neg = (a_c[COORD_W-1] != b_c[COORD_W-1]) && (a_c != '0) && (b_c != '0);
    if (sa_next.origin) den_next = 17'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
    end else begin
      sa.valid <= sa_next.valid;
    end
    sa.origin <= sa_next.origin;
    sa.neg    <= sa_next.neg;
    sa.wedge  <= sa_next.wedge;
    sa.radius <= sa_next.radius;
    num_r <= num_next;
    den_r <= den_next;
  end

  logic [F:0] quo;
  side_t      sq;

  csdm_divider #(.FRAC_BITS(F)) u_div (
    .clk(clk), .rst(rst), .num(num_r), .den(den_r), .side_in(sa),
    .quo(quo), .side_out(sq)
  );

  // Stage: angle scaling by pi/4.
  logic [PW-1:0] prod_next;
  logic [PW-1:0] prod;
  side_t         sp;
  always_comb begin
    prod_next = PW'(quo) * PW'(PI4_Q30) + PW'(30'h20000000);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      sp.valid <= 1'b0;
    end else begin
      sp.valid <= sq.valid;
    end
    sp.origin <= sq.origin;
    sp.neg    <= sq.neg;
    sp.wedge  <= sq.wedge;
    sp.radius <= sq.radius;
    prod <= prod_next;
  end

  logic signed [TW-1:0] theta_r;
  side_t                st;
  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else begin
      st.valid <= sp.valid;
    end
    st.origin <= sp.origin;
    st.neg    <= sp.neg;
    st.wedge  <= sp.wedge;
    st.radius <= sp.radius;
    theta_r <= sp.neg ? -$signed({2'b00, prod[F+30:30]})
                      : $signed({2'b00, prod[F+30:30]});
  end

  logic signed [TW-1:0] cv, sv;
  side_t                sc;

  csdm_cordic #(.FRAC_BITS(F), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst(rst), .theta(theta_r), .side_in(st),
    .cos_out(cv), .sin_out(sv), .side_out(sc)
  );

  // Stage: wedge swap and radius multiply.
  logic signed [TW-1:0]   px, py;
  logic signed [TW+18:0]  mx, my;
  side_t                  sm;
  always_comb begin
    case (sc.wedge)
      WEDGE_EAST:  begin px = cv;  py = sv;  end
      WEDGE_NORTH: begin px = sv;  py = cv;  end
      WEDGE_WEST:  begin px = -cv; py = -sv; end
      WEDGE_SOUTH: begin px = -sv; py = -cv; end
      default:     begin px = cv;  py = sv;  end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      sm.valid <= 1'b0;
    end else begin
      sm.valid <= sc.valid;
    end
    sm.origin <= sc.origin;
    sm.neg    <= sc.neg;
    sm.wedge  <= sc.wedge;
    sm.radius <= sc.radius;
    mx <= (TW+19)'($signed({1'b0, sc.radius})) * (TW+19)'(px);
    my <= (TW+19)'($signed({1'b0, sc.radius})) * (TW+19)'(py);
  end

  // Stage: rounding and saturation.
  logic signed [TW+18:0] rx, ry;
  logic signed [TW+18:0] hx, hy;
  always_comb begin
    hx = (mx + (TW+19)'(1 << (F - 1))) >>> F;
    hy = (my + (TW+19)'(1 << (F - 1))) >>> F;
    rx = hx;
    ry = hy;
    if (hx > (TW+19)'(OUT_MAX)) rx = (TW+19)'(OUT_MAX);
    if (hx < -(TW+19)'(OUT_MAX)) rx = -(TW+19)'(OUT_MAX);
    if (hy > (TW+19)'(OUT_MAX)) ry = (TW+19)'(OUT_MAX);
    if (hy < -(TW+19)'(OUT_MAX)) ry = -(TW+19)'(OUT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= sm.valid;
    end
    disk_x <= sm.origin ? '0 : rx[OUT_W-1:0];
    disk_y <= sm.origin ? '0 : ry[OUT_W-1:0];
  end

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(sm.origin) |-> disk_x == '0 && disk_y == '0)
    else $error("origin gave nonzero output");
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> disk_x <= OUT_W'(OUT_MAX) && disk_x >= -OUT_W'(OUT_MAX))
    else $error("disk_x out of range");
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> disk_y <= OUT_W'(OUT_MAX) && disk_y >= -OUT_W'(OUT_MAX))
    else $error("disk_y out of range");
  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    sm.valid |=> strobe)
    else $error("result lost at output stage");

endmodule

// File: verif/concentric_square_to_disk_map_unit_tb.sv
`timescale 1ns / 1ps
module concentric_square_to_disk_map_unit_tb;
  import csdm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int NSTG = CORDIC_STAGES_DEF;
  localparam int LATENCY = FB + NSTG + 7;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;

  typedef struct packed {
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
  } disk_point_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [SAMPLE_W-1:0] sample_x;
  logic [SAMPLE_W-1:0] sample_y;
  logic strobe;
  logic signed [OUT_W-1:0] disk_x;
  logic signed [OUT_W-1:0] disk_y;

  disk_point_t expected_points[$];
  int error_count;
  int idle_cycles;
  bit gaps_on;

  concentric_square_to_disk_map_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_x(sample_x), .sample_y(sample_y),
    .strobe(strobe), .disk_x(disk_x), .disk_y(disk_y)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [OUT_W-1:0] scale_to_disk(longint prod);
    longint v;
    v = floor_shift(prod + (64'sd1 <<< (FB - 1)), FB);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < -OUT_MAX) v = -OUT_MAX;
    return v[OUT_W-1:0];
  endfunction

  function automatic disk_point_t map_to_disk(logic [SAMPLE_W-1:0] ux, logic [SAMPLE_W-1:0] uy);
    longint a, b, rad, num, den, theta, cx, sy, z, xs, ys, step, cv, sv;
    longint unsigned q, th, mn, md;
    wedge_t wedge;
    disk_point_t res;
    a = 2 * longint'(ux) - 65536;
    b = 2 * longint'(uy) - 65536;
    if (a > -b) begin
      if (a > b) begin wedge = WEDGE_EAST; rad = a; num = b; den = a; end
      else begin wedge = WEDGE_NORTH; rad = b; num = a; den = b; end
    end else begin
      if (a < b) begin wedge = WEDGE_WEST; rad = -a; num = b; den = a; end
      else begin wedge = WEDGE_SOUTH; rad = -b; num = a; den = b; end
    end
    if (den == 0) begin
      res.px = '0;
      res.py = '0;
      return res;
    end
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = ((mn << FB) + md / 2) / md;
    th = (q * longint'(PI4_Q30) + (64'd1 << 29)) >> 30;
    theta = th;
    if ((num < 0) != (den < 0)) theta = -theta;
    cx = longint'(GAIN_Q30) >> (30 - FB);
    sy = 0;
    z = theta;
    for (int i = 0; i < NSTG && i < ATAN_COUNT; i++) begin
      xs = floor_shift(cx, i);
      ys = floor_shift(sy, i);
      step = longint'(atan_q30(i)) >> (30 - FB);
      if (z >= 0) begin cx -= ys; sy += xs; z -= step; end
      else begin cx += ys; sy -= xs; z += step; end
    end
    case (wedge)
      WEDGE_EAST: begin cv = cx; sv = sy; end
      WEDGE_NORTH: begin cv = sy; sv = cx; end
      WEDGE_WEST: begin cv = -cx; sv = -sy; end
      default: begin cv = -sy; sv = -cx; end
    endcase
    res.px = scale_to_disk(rad * cv);
    res.py = scale_to_disk(rad * sv);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Drive one word and hold it until the block takes it; optional gap first.
  task automatic send_sample(logic [SAMPLE_W-1:0] ux, logic [SAMPLE_W-1:0] uy);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    start <= 1'b1;
    sample_x <= ux;
    sample_y <= uy;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_points = {expected_points, map_to_disk(ux, uy)};
    @(negedge clk);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    sample_x <= SAMPLE_W'($urandom);
    sample_y <= SAMPLE_W'($urandom);
  endtask

  always @(posedge clk) begin
    disk_point_t want;
    if (!rst && strobe) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word count", 1, 0);
      end else begin
        want = expected_points.pop_front();
        if (disk_x !== want.px) report_mismatch("disk_x", disk_x, want.px);
        if (disk_y !== want.py) report_mismatch("disk_y", disk_y, want.py);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("concentric_square_to_disk_map_unit test failed");
      $finish;
    end
  end

  task automatic test_corners_and_axes();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'hFFFF, 16'h8000);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h8000, 16'hFFFF);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h8001, 16'h8000);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'hAAAA, 16'h5555);
  endtask

  task automatic test_diagonals_and_wedges();
    send_sample(16'hC000, 16'hC000);
    send_sample(16'h4000, 16'hC000);
    send_sample(16'h4000, 16'h4000);
    send_sample(16'hC000, 16'h4000);
    send_sample(16'hF000, 16'hA000);
    send_sample(16'hA000, 16'hF000);
    send_sample(16'h1000, 16'h6000);
    send_sample(16'h6000, 16'h1000);
    send_sample(16'hFFFE, 16'h8001);
    send_sample(16'h8001, 16'h0001);
  endtask

  task automatic test_random_samples(int count);
    logic [SAMPLE_W-1:0] ux, uy;
    int d;
    for (int n = 0; n < count; n++) begin
      ux = SAMPLE_W'($urandom);
      uy = SAMPLE_W'($urandom);
      case ($urandom_range(0, 5))
        0: uy = SAMPLE_W'(16'hFFFF - ux + 1);
        1: uy = ux;
        2: begin d = $urandom_range(0, 4); ux = SAMPLE_W'(32'h8000 + d - 2); end
        default: ;
      endcase
      send_sample(ux, uy);
    end
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    sample_x = '0;
    sample_y = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corners_and_axes();
    test_diagonals_and_wedges();
    test_random_samples(700);
    gaps_on = 1'b0;
    test_random_samples(230);
    stop_sending();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("concentric_square_to_disk_map_unit test passed");
    end else begin
      $display("concentric_square_to_disk_map_unit test failed");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/csdm_pkg.sv
hw/rtl/csdm_divider.sv
hw/rtl/csdm_cordic.sv
hw/rtl/concentric_square_to_disk_map_unit.sv
verif/concentric_square_to_disk_map_unit_tb.sv
